@@ src/bsdq_pkg.sv @@
package bsdq_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 10;
    localparam int CNT_OUT_W = 9;
    localparam int CMP_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_INSERT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_POP    = 2'd1,
        CELL_INSERT = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [CNT_W-1:0]   pos;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

@@ src/bsdq_cell.sv @@
module bsdq_cell import bsdq_pkg::*; (
    input  logic               i_clk,
    input  logic [IDX_W-1:0]   i_index,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    output logic signed [31:0] o_data
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic [CNT_W-1:0]   w_index;

    assign w_index = CNT_W'(i_index);

    // pop: take the item from the tail side; insert: open a gap at pos
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_POP: begin
                n_data = i_right;
            end
            CELL_INSERT: begin
                if (w_index > i_ctl.pos) begin
                    n_data = i_left;
                end else if (w_index == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ src/bounded_sequence_deque_insert.sv @@
// Bounded deque of signed 32-bit items with positional insert.
// The sequence sits in a row of DEPTH cells in order, cell 0 holding the head.
// Command channel: i_command, i_value, i_position are taken at a rising edge
// with start high and busy low. Append, push and insert shift the cells from
// the insert point one place toward the tail; remove shifts all
// cells one place toward the head.
// Result channel: o_done is high for exactly one cycle, the cycle after the
// command is taken, with o_status, o_removed_item and o_item_count (count after
// the command). The receiver cannot stall; every result is taken that cycle.
// busy is high during the result cycle, so the block takes no new command
// until the result of the last one has been shown.
// Reset (synchronous, active low) empties the sequence and clears done and
// busy; cell contents are not cleared and are never read before written.
module bounded_sequence_deque_insert import bsdq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_command,
    input  logic signed [31:0]     i_value,
    input  logic signed [POS_W-1:0] i_position,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic signed [31:0]     o_removed_item,
    output logic [CNT_OUT_W-1:0]   o_item_count
);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_done;
    t_status            r_status;
    t_status            n_status;
    logic signed [31:0] r_removed;
    logic signed [31:0] n_removed;
    t_cell_ctl          w_ctl;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_badpos;
    logic [CMP_W-1:0]   w_praw;
    logic [CMP_W-1:0]   w_count_ext;
    logic signed [31:0] w_cell [DEPTH];

    assign w_accept    = start && !busy;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_praw      = CMP_W'(i_position[POS_W-2:0]);
    assign w_count_ext = CMP_W'(r_count);
    assign w_badpos    = i_position[POS_W-1] || (w_praw > w_count_ext);

    always_comb begin
        n_count   = r_count;
        n_status  = ST_OK;
        n_removed = '0;
        w_ctl.op    = CELL_HOLD;
        w_ctl.pos   = '0;
        w_ctl.value = i_value;
        if (w_accept) begin
            unique case (t_cmd'(i_command))
                CMD_APPEND: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.op  = CELL_INSERT;
                        w_ctl.pos = r_count;
                        n_count   = r_count + 1'b1;
                    end
                end
                CMD_PUSH: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.op  = CELL_INSERT;
                        w_ctl.pos = '0;
                        n_count   = r_count + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.op  = CELL_POP;
                        n_removed = w_cell[0];
                        n_count   = r_count - 1'b1;
                    end
                end
                CMD_INSERT: begin
                    if (w_badpos) begin
                        n_status = ST_BADPOS;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.op  = CELL_INSERT;
                        w_ctl.pos = w_praw[CNT_W-1:0];
                        n_count   = r_count + 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end
        bsdq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign busy           = r_done;
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_removed_item = r_removed;
    assign o_item_count   = w_count_ext[CNT_OUT_W-1:0];

endmodule

@@ test/deque_command_checker.sv @@
module deque_command_checker import bsdq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              i_command,
    input  logic signed [31:0]      i_value,
    input  logic signed [POS_W-1:0] i_position,
    input  logic                    o_done,
    input  logic [1:0]              o_status,
    input  logic signed [31:0]      o_removed_item,
    input  logic [CNT_OUT_W-1:0]    o_item_count,
    output int                      fail_count,
    output int                      pending_results,
    output int                      seq_length
);

    typedef struct {
        t_status               status;
        logic signed [31:0]    removed;
        logic [CNT_OUT_W-1:0]  count;
    } t_deque_result;

    logic signed [31:0] held_items [$];
    t_deque_result      expected_results [$];

    function automatic t_deque_result apply_command(t_cmd cmd, logic signed [31:0] val,
                                                    logic signed [POS_W-1:0] pos);
        t_deque_result res;
        res.status  = ST_OK;
        res.removed = '0;
        case (cmd)
            CMD_APPEND: begin
                if (held_items.size() >= DEPTH) res.status = ST_FULL;
                else held_items.push_back(val);
            end
            CMD_PUSH: begin
                if (held_items.size() >= DEPTH) res.status = ST_FULL;
                else held_items.push_front(val);
            end
            CMD_REMOVE: begin
                if (held_items.size() == 0) res.status = ST_EMPTY;
                else res.removed = held_items.pop_front();
            end
            default: begin
                // position is checked before fullness
                if (pos < 0 || int'(pos) > held_items.size()) res.status = ST_BADPOS;
                else if (held_items.size() >= DEPTH) res.status = ST_FULL;
                else held_items.insert(int'(pos), val);
            end
        endcase
        res.count = CNT_OUT_W'(held_items.size());
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            held_items.delete();
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_removed_item !== want.removed) begin
                        $error("removed_item: expected %0d, actual %0d",
                               want.removed, o_removed_item);
                        fail_count++;
                    end
                    if (o_item_count !== want.count) begin
                        $error("item_count: expected %0d, actual %0d",
                               want.count, o_item_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_command(t_cmd'(i_command), i_value,
                                                         i_position));
        end
        pending_results = expected_results.size();
        seq_length      = held_items.size();
    end

endmodule

@@ test/bounded_sequence_deque_insert_tb.sv @@
module bounded_sequence_deque_insert_tb;
    import bsdq_pkg::*;

    localparam int ITEM_TARGET  = 650;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_command;
    logic signed [31:0]      i_value;
    logic signed [POS_W-1:0] i_position;
    logic                    o_done;
    logic [1:0]              o_status;
    logic signed [31:0]      o_removed_item;
    logic [CNT_OUT_W-1:0]    o_item_count;

    int fail_count;
    int pending_results;
    int seq_length;
    int items_sent;
    int stall_cycles;
    int mixed_items;
    int r;
    bit steady_run;

    bounded_sequence_deque_insert dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_removed_item (o_removed_item),
        .o_item_count   (o_item_count)
    );

    deque_command_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_removed_item  (o_removed_item),
        .o_item_count    (o_item_count),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .seq_length      (seq_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("bounded_sequence_deque_insert verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (steady_run) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [POS_W-1:0] bad_position(int len);
        if ($urandom_range(0, 1)) return POS_W'(-$urandom_range(1, 512));
        return POS_W'($urandom_range(len + 1, 511));
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic issue(input t_cmd cmd, input logic signed [31:0] val,
                         input logic signed [POS_W-1:0] pos);
        int gap;
        if (items_sent % 50 == 0) steady_run = ($urandom_range(0, 9) < 3);
        start      = 1'b1;
        i_command  = cmd;
        i_value    = val;
        i_position = pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start      = 1'b0;
            i_command  = 2'($urandom_range(0, 3));
            i_value    = $urandom;
            i_position = POS_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic add_random();
        int pick;
        pick = $urandom_range(0, 2);
        case (pick)
            0: issue(CMD_APPEND, $urandom, POS_W'($urandom));
            1: issue(CMD_PUSH, $urandom, POS_W'($urandom));
            default: issue(CMD_INSERT, $urandom, POS_W'($urandom_range(0, seq_length)));
        endcase
    endtask

    initial begin
        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_command    = CMD_APPEND;
        i_value      = '0;
        i_position   = '0;
        items_sent   = 0;
        stall_cycles = 0;
        mixed_items  = 0;
        steady_run   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        issue(CMD_REMOVE, 32'h1234_5678, 10'sd0);
        issue(CMD_INSERT, 32'h0000_0011, -10'sd1);
        issue(CMD_INSERT, 32'h0000_0022, 10'sd1);
        issue(CMD_INSERT, 32'h7FFF_FFFF, 10'sd0);
        issue(CMD_APPEND, 32'h8000_0000, 10'sd0);
        issue(CMD_PUSH, 32'h0000_0000, 10'h3FF);
        issue(CMD_PUSH, 32'hFFFF_FFFF, 10'h155);
        issue(CMD_INSERT, 32'h5555_5555, 10'sd2);
        issue(CMD_INSERT, 32'hAAAA_AAAA, 10'sd5);
        issue(CMD_INSERT, 32'h0000_0033, 10'h200);
        issue(CMD_INSERT, 32'h0000_0044, 10'h1FF);
        issue(CMD_INSERT, 32'h0000_0055, 10'sd7);
        issue(CMD_INSERT, 32'h0000_0001, 10'sd0);
        repeat (8) issue(CMD_REMOVE, $urandom, 10'h2AA);

        // grow until full
        while (seq_length < DEPTH) begin
            r = $urandom_range(0, 99);
            if (r < 90) add_random();
            else if (r < 97) issue(CMD_REMOVE, $urandom, POS_W'($urandom));
            else issue(CMD_INSERT, $urandom, bad_position(seq_length));
        end

        // while full: bad position wins over full
        issue(CMD_INSERT, $urandom, 10'sd257);
        issue(CMD_INSERT, $urandom, -10'sd1);
        issue(CMD_INSERT, $urandom, 10'sd256);
        issue(CMD_INSERT, $urandom, 10'sd0);
        issue(CMD_APPEND, $urandom, POS_W'($urandom));
        issue(CMD_PUSH, $urandom, POS_W'($urandom));

        // shrink until empty
        while (seq_length > 0) begin
            r = $urandom_range(0, 99);
            if (r < 93) issue(CMD_REMOVE, $urandom, POS_W'($urandom));
            else add_random();
        end

        while (items_sent < ITEM_TARGET || mixed_items < 40) begin
            r = $urandom_range(0, 3);
            case (r)
                0: issue(CMD_APPEND, $urandom, POS_W'($urandom));
                1: issue(CMD_PUSH, $urandom, POS_W'($urandom));
                2: issue(CMD_REMOVE, $urandom, POS_W'($urandom));
                default: begin
                    if ($urandom_range(0, 3) != 0)
                        issue(CMD_INSERT, $urandom,
                              POS_W'($urandom_range(0, seq_length)));
                    else
                        issue(CMD_INSERT, $urandom, bad_position(seq_length));
                end
            endcase
            mixed_items++;
        end

        start = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("bounded_sequence_deque_insert verification clean");
        end else begin
            $display("bounded_sequence_deque_insert verification failed");
        end
        $finish;
    end

endmodule
